// File: hdl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// shared widths, constants, sector codes and stage payload types
// ----------------------------------------------------------------------------
package hsv_pkg;

   localparam int HUE_W   = 9;
   localparam int LEVEL_W = 8;
   localparam int REM_W   = 6;
   localparam int NUM_W   = 14;
   localparam int XQ_W    = 22;
   localparam int YP_W    = 16;

   localparam logic [HUE_W-1:0]   HUE_MAX    = 9'd359;
   localparam logic [HUE_W-1:0]   SECTOR_DEG = 9'd60;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
   localparam logic [NUM_W-1:0]   SCALE_Q    = 14'd15300;

   // reciprocal constants: floor(2^shift / divisor), quotient low by at most one
   localparam logic [8:0] RECIP_Q = 9'd274;
   localparam int         SHIFT_Q = 22;
   localparam logic [8:0] RECIP_P = 9'd257;
   localparam int         SHIFT_P = 16;

   typedef enum logic [2:0] {
      SEC_R_TO_Y = 3'd0,
      SEC_Y_TO_G = 3'd1,
      SEC_G_TO_C = 3'd2,
      SEC_C_TO_B = 3'd3,
      SEC_B_TO_M = 3'd4,
      SEC_M_TO_R = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type         sector;
      logic [REM_W-1:0]   rem;
      logic [LEVEL_W-1:0] sat;
      logic [LEVEL_W-1:0] val;
   } sec_type;

   typedef struct packed {
      sector_type         sector;
      logic [LEVEL_W-1:0] val;
      logic [XQ_W-1:0]    x_q;
      logic [XQ_W-1:0]    x_t;
      logic [YP_W-1:0]    y_p;
   } prod_type;

   typedef struct packed {
      sector_type         sector;
      logic [LEVEL_W-1:0] val;
      logic [LEVEL_W-1:0] p;
      logic [LEVEL_W-1:0] q;
      logic [LEVEL_W-1:0] t;
   } lvl_type;

endpackage

// File: hdl/hsv_sector.sv
// ----------------------------------------------------------------------------
// hsv_sector
// hue clamp and split into sector and remainder, one register stage
// ----------------------------------------------------------------------------
module hsv_sector import hsv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [HUE_W-1:0]   hue,
   input  logic [LEVEL_W-1:0] sat,
   input  logic [LEVEL_W-1:0] val,
   output logic               out_valid,
   input  logic               out_ready,
   output sec_type            out_data
);

   logic               valid_ff;
   sec_type            data_ff;
   sec_type            data_in;
   logic [HUE_W-1:0]   hue_sat;
   logic [HUE_W-1:0]   base;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      hue_sat = (hue > HUE_MAX) ? HUE_MAX : hue;
      priority if (hue_sat >= 9'(5 * SECTOR_DEG)) begin
         data_in.sector = SEC_M_TO_R;
         base = 9'(5 * SECTOR_DEG);
      end else if (hue_sat >= 9'(4 * SECTOR_DEG)) begin
         data_in.sector = SEC_B_TO_M;
         base = 9'(4 * SECTOR_DEG);
      end else if (hue_sat >= 9'(3 * SECTOR_DEG)) begin
         data_in.sector = SEC_C_TO_B;
         base = 9'(3 * SECTOR_DEG);
      end else if (hue_sat >= 9'(2 * SECTOR_DEG)) begin
         data_in.sector = SEC_G_TO_C;
         base = 9'(2 * SECTOR_DEG);
      end else if (hue_sat >= SECTOR_DEG) begin
         data_in.sector = SEC_Y_TO_G;
         base = SECTOR_DEG;
      end else begin
         data_in.sector = SEC_R_TO_Y;
         base = '0;
      end
      data_in.rem = REM_W'(hue_sat - base);
      data_in.sat = sat;
      data_in.val = val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: hdl/hsv_mult.sv
// ----------------------------------------------------------------------------
// hsv_mult
// numerators of p, q and t, then their products with the value, two stages
// ----------------------------------------------------------------------------
module hsv_mult import hsv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  sec_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output prod_type out_data
);

   typedef struct packed {
      sector_type         sector;
      logic [LEVEL_W-1:0] val;
      logic [NUM_W-1:0]   num_q;
      logic [NUM_W-1:0]   num_t;
      logic [LEVEL_W-1:0] inv_s;
   } num_type;

   logic               num_valid_ff;
   num_type            num_ff;
   num_type            num_in;
   logic               num_ready;
   logic               prod_valid_ff;
   prod_type           prod_ff;
   prod_type           prod_in;
   logic [REM_W:0]     k_t;

   assign num_ready = !prod_valid_ff || out_ready;
   assign in_ready  = !num_valid_ff || num_ready;
   assign out_valid = prod_valid_ff;
   assign out_data  = prod_ff;

   // s*rem and s*(60-rem) never exceed 15300
   always_comb begin
      k_t = (REM_W+1)'(SECTOR_DEG) - {1'b0, in_data.rem};
      num_in.sector = in_data.sector;
      num_in.val    = in_data.val;
      num_in.num_q  = SCALE_Q - NUM_W'(in_data.sat) * NUM_W'(in_data.rem);
      num_in.num_t  = SCALE_Q - NUM_W'(in_data.sat) * NUM_W'(k_t);
      num_in.inv_s  = LEVEL_FULL - in_data.sat;
   end

   always_comb begin
      prod_in.sector = num_ff.sector;
      prod_in.val    = num_ff.val;
      prod_in.x_q    = XQ_W'(num_ff.val) * XQ_W'(num_ff.num_q);
      prod_in.x_t    = XQ_W'(num_ff.val) * XQ_W'(num_ff.num_t);
      prod_in.y_p    = YP_W'(num_ff.val) * YP_W'(num_ff.inv_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            num_valid_ff <= in_valid;
         end
         if (num_ready) begin
            prod_valid_ff <= num_valid_ff;
         end
      end
      if (in_ready && in_valid) begin
         num_ff <= num_in;
      end
      if (num_ready && num_valid_ff) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// File: hdl/hsv_div.sv
// ----------------------------------------------------------------------------
// hsv_div
// constant division by reciprocal multiply, then a one-step correction
// ----------------------------------------------------------------------------
module hsv_div import hsv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  prod_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output lvl_type  out_data
);

   typedef struct packed {
      sector_type         sector;
      logic [LEVEL_W-1:0] val;
      logic [XQ_W-1:0]    x_q;
      logic [XQ_W-1:0]    x_t;
      logic [YP_W-1:0]    y_p;
      logic [LEVEL_W-1:0] q0_q;
      logic [LEVEL_W-1:0] q0_t;
      logic [LEVEL_W-1:0] q0_p;
   } est_type;

   localparam int PQ_W = XQ_W + 9;
   localparam int PP_W = YP_W + 9;

   logic             est_valid_ff;
   est_type          est_ff;
   est_type          est_in;
   logic             est_ready;
   logic             lvl_valid_ff;
   lvl_type          lvl_ff;
   lvl_type          lvl_in;
   logic [PQ_W-1:0]  pq_q;
   logic [PQ_W-1:0]  pq_t;
   logic [PP_W-1:0]  pp_p;

   function automatic logic [LEVEL_W-1:0] fix_q(logic [XQ_W-1:0] x, logic [LEVEL_W-1:0] q0);
      logic [XQ_W-1:0] r;
      r = x - XQ_W'(q0) * XQ_W'(SCALE_Q);
      return (r >= XQ_W'(SCALE_Q)) ? q0 + 8'd1 : q0;
   endfunction

   function automatic logic [LEVEL_W-1:0] fix_p(logic [YP_W-1:0] y, logic [LEVEL_W-1:0] q0);
      logic [YP_W-1:0] r;
      r = y - YP_W'(q0) * YP_W'(LEVEL_FULL);
      return (r >= YP_W'(LEVEL_FULL)) ? q0 + 8'd1 : q0;
   endfunction

   assign est_ready = !lvl_valid_ff || out_ready;
   assign in_ready  = !est_valid_ff || est_ready;
   assign out_valid = lvl_valid_ff;
   assign out_data  = lvl_ff;

   always_comb begin
      pq_q = PQ_W'(in_data.x_q) * PQ_W'(RECIP_Q);
      pq_t = PQ_W'(in_data.x_t) * PQ_W'(RECIP_Q);
      pp_p = PP_W'(in_data.y_p) * PP_W'(RECIP_P);
      est_in.sector = in_data.sector;
      est_in.val    = in_data.val;
      est_in.x_q    = in_data.x_q;
      est_in.x_t    = in_data.x_t;
      est_in.y_p    = in_data.y_p;
      est_in.q0_q   = pq_q[SHIFT_Q +: LEVEL_W];
      est_in.q0_t   = pq_t[SHIFT_Q +: LEVEL_W];
      est_in.q0_p   = pp_p[SHIFT_P +: LEVEL_W];
   end

   always_comb begin
      lvl_in.sector = est_ff.sector;
      lvl_in.val    = est_ff.val;
      lvl_in.q      = fix_q(est_ff.x_q, est_ff.q0_q);
      lvl_in.t      = fix_q(est_ff.x_t, est_ff.q0_t);
      lvl_in.p      = fix_p(est_ff.y_p, est_ff.q0_p);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_valid_ff <= 1'b0;
         lvl_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            est_valid_ff <= in_valid;
         end
         if (est_ready) begin
            lvl_valid_ff <= est_valid_ff;
         end
      end
      if (in_ready && in_valid) begin
         est_ff <= est_in;
      end
      if (est_ready && est_valid_ff) begin
         lvl_ff <= lvl_in;
      end
   end

`ifndef SYNTHESIS
   // q and p estimates never overshoot the true quotient
   a_est_low: assert property (@(posedge clock) disable iff (reset)
      est_valid_ff |-> (XQ_W'(est_ff.q0_q) * XQ_W'(SCALE_Q) <= est_ff.x_q) &&
                       (YP_W'(est_ff.q0_p) * YP_W'(LEVEL_FULL) <= est_ff.y_p))
      else $error("reciprocal estimate above quotient");

   // q estimate is short by at most one
   a_est_close: assert property (@(posedge clock) disable iff (reset)
      est_valid_ff |-> (est_ff.x_q - XQ_W'(est_ff.q0_q) * XQ_W'(SCALE_Q)
                        < 2 * XQ_W'(SCALE_Q)))
      else $error("reciprocal estimate off by more than one");

   // p, q and t never exceed the value level
   a_lvl_range: assert property (@(posedge clock) disable iff (reset)
      lvl_valid_ff |-> (lvl_ff.p <= lvl_ff.val) && (lvl_ff.q <= lvl_ff.val) &&
                       (lvl_ff.t <= lvl_ff.val))
      else $error("level above value");
`endif

endmodule

// File: hdl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// 8-bit hsv to rgb pixel converter, six-stage pipeline that, unless the response stalls, takes one pixel per clock
// ----------------------------------------------------------------------------
// A request carries hue in degrees (values above 359 are treated as 359),
// saturation and value; the response carries red, green and blue. Every
// request gives exactly one response, in order, with exact integer floors
// for p = v(255-s)/255, q = v(15300-s*rem)/15300 and t = v(15300-s(60-rem))/15300.
// A new request is taken every cycle while the response is not stalled;
// each pixel passes through the six register stages (hue split,
// numerator multiply, value multiply, reciprocal estimate, correction,
// channel placement). Each stage holds its own valid bit and fills
// independently, so bubbles close up while the response is stalled
// and req_ready only drops when all six stages hold a pixel.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter import hsv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [HUE_W-1:0]   req_hue_deg,
   input  logic [LEVEL_W-1:0] req_sat_level,
   input  logic [LEVEL_W-1:0] req_val_level,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LEVEL_W-1:0] rsp_red_out,
   output logic [LEVEL_W-1:0] rsp_green_out,
   output logic [LEVEL_W-1:0] rsp_blue_out
);

   // stage handshakes
   logic     sec_valid;
   logic     sec_ready;
   sec_type  sec_data;
   logic     prod_valid;
   logic     prod_ready;
   prod_type prod_data;
   logic     lvl_valid;
   logic     lvl_ready;
   lvl_type  lvl_data;

   // output stage
   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] red_ff;
   logic [LEVEL_W-1:0] green_ff;
   logic [LEVEL_W-1:0] blue_ff;
   logic [LEVEL_W-1:0] red_in;
   logic [LEVEL_W-1:0] green_in;
   logic [LEVEL_W-1:0] blue_in;

   // stage 1: clamp hue, sector and remainder
   hsv_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .hue       (req_hue_deg),
      .sat       (req_sat_level),
      .val       (req_val_level),
      .out_valid (sec_valid),
      .out_ready (sec_ready),
      .out_data  (sec_data)
   );

   // stages 2 and 3: numerators, then products with value
   hsv_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sec_valid),
      .in_ready  (sec_ready),
      .in_data   (sec_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   // stages 4 and 5: divide by 15300 and 255
   hsv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (lvl_valid),
      .out_ready (lvl_ready),
      .out_data  (lvl_data)
   );

   // stage 6: place v, p, q, t on the channels by sector
   assign lvl_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (lvl_data.sector)
         SEC_R_TO_Y: begin
            red_in = lvl_data.val; green_in = lvl_data.t; blue_in = lvl_data.p;
         end
         SEC_Y_TO_G: begin
            red_in = lvl_data.q; green_in = lvl_data.val; blue_in = lvl_data.p;
         end
         SEC_G_TO_C: begin
            red_in = lvl_data.p; green_in = lvl_data.val; blue_in = lvl_data.t;
         end
         SEC_C_TO_B: begin
            red_in = lvl_data.p; green_in = lvl_data.q; blue_in = lvl_data.val;
         end
         SEC_B_TO_M: begin
            red_in = lvl_data.t; green_in = lvl_data.p; blue_in = lvl_data.val;
         end
         default: begin
            red_in = lvl_data.val; green_in = lvl_data.p; blue_in = lvl_data.q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (lvl_ready) begin
         rsp_valid_ff <= lvl_valid;
      end
      if (lvl_ready && lvl_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;

`ifndef SYNTHESIS
   // backpressure at the input only when the output is blocked
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a blocked response");

   // a response appears only from a filled correction stage
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(lvl_valid))
      else $error("response without a pixel behind it");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule
